// File: rtl/core/fsa_pkg.sv
// Package for the fit-strategy allocator: segment and cell-op types, codes and constants.
// Used by fsa_cell and fit_strategy_allocator_unit; depends on nothing else.
`default_nettype none

package fsa_pkg;

    localparam int unsigned MAX_SEGMENTS = 64;
    localparam int unsigned ADDR_BITS    = 16;
    localparam int unsigned SIZE_BITS    = ADDR_BITS + 1;

    localparam logic [SIZE_BITS-1:0] POOL_CAP = SIZE_BITS'(1) << ADDR_BITS;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_PROBE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_BEST  = 2'd1,
        STRAT_WORST = 2'd2,
        STRAT_NEXT  = 2'd3
    } t_strategy;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_NOFIT  = 2'd1,
        STS_FULL   = 2'd2,
        STS_BADOFF = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_STRATEGY = 2'd0,
        CFG_POOL     = 2'd1,
        CFG_SMALL    = 2'd2,
        CFG_SPARE    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_ROTATE    = 3'd1,
        OP_INIT      = 3'd2,
        OP_MARK_USED = 3'd3,
        OP_MARK_FREE = 3'd4,
        OP_SPLIT     = 3'd5,
        OP_MERGE     = 3'd6
    } t_cell_code;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
        logic                 used;
    } t_seg;

    typedef struct packed {
        t_cell_code           code;
        logic [SIZE_BITS-1:0] req;
        logic [SIZE_BITS-1:0] init_size;
    } t_cell_op;

    function automatic logic [SIZE_BITS-1:0] clamp_pool(input logic [SIZE_BITS-1:0] v);
        clamp_pool = (v > POOL_CAP) ? POOL_CAP : v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fsa_cell.sv
// One segment cell of the allocator chain: holds start, size and used mark.
// Loads from its left or right neighbor on broadcast ops; uses fsa_pkg.
`default_nettype none

module fsa_cell #(
    parameter int unsigned NUM = fsa_pkg::MAX_SEGMENTS,
    parameter int unsigned IDX = 0
) (
    input  wire logic                   i_clk,
    input  wire fsa_pkg::t_cell_op      i_op,
    input  wire logic [$clog2(NUM)-1:0] i_idx,
    input  wire fsa_pkg::t_seg          i_left,
    input  wire fsa_pkg::t_seg          i_right,
    output fsa_pkg::t_seg               o_seg
);

    localparam int unsigned IW = $clog2(NUM);
    localparam logic [IW:0] K  = (IW+1)'(IDX);

    fsa_pkg::t_seg r_seg;
    fsa_pkg::t_seg n_seg;
    logic [IW:0]   w_j;
    logic [IW:0]   w_j1;

    assign w_j  = {1'b0, i_idx};
    assign w_j1 = w_j + (IW+1)'(1);

    always_comb begin
        n_seg = r_seg;
        case (i_op.code)
            fsa_pkg::OP_ROTATE: begin
                n_seg = i_right;
            end
            fsa_pkg::OP_INIT: begin
                if (K == '0) begin
                    n_seg.start = '0;
                    n_seg.size  = i_op.init_size;
                    n_seg.used  = 1'b0;
                end
            end
            fsa_pkg::OP_MARK_USED: begin
                if (K == w_j) n_seg.used = 1'b1;
            end
            fsa_pkg::OP_MARK_FREE: begin
                if (K == w_j) n_seg.used = 1'b0;
            end
            fsa_pkg::OP_SPLIT: begin
                if (K == w_j) begin
                    n_seg.size = i_op.req;
                    n_seg.used = 1'b1;
                end else if (K == w_j1) begin
                    n_seg.start = i_left.start + i_op.req[fsa_pkg::ADDR_BITS-1:0];
                    n_seg.size  = i_left.size - i_op.req;
                    n_seg.used  = 1'b0;
                end else if (K > w_j1) begin
                    n_seg = i_left;
                end
            end
            fsa_pkg::OP_MERGE: begin
                if (K == w_j) begin
                    n_seg.size = r_seg.size + i_right.size;
                end else if (K > w_j) begin
                    n_seg = i_right;
                end
            end
            default: begin
                n_seg = r_seg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign o_seg = r_seg;

endmodule

`default_nettype wire

// File: rtl/core/fit_strategy_allocator_unit.sv
// Fit-strategy pool allocator: a ring of MAX_SEGMENTS segment cells scanned by rotation.
// Each item takes one full rotation to search, a decision state, three edit states,
// one full rotation to gather statistics and a result state.
// New items are refused (o_stall) until the previous result is registered, longer while a result is stalled.
// Synchronous active-low reset gives one free segment of the whole pool, cursor zero;
// a strategy or pool-size write re-initializes the table. Uses fsa_pkg, fsa_cell.
`default_nettype none

module fit_strategy_allocator_unit #(
    parameter int unsigned MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [16:0] i_request_size,
    input  wire logic [15:0] i_offset,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_result_offset,
    output logic             o_is_allocated,
    output logic [6:0]       o_free_segs,
    output logic [16:0]      o_free_total,
    output logic [16:0]      o_used_total,
    output logic [16:0]      o_largest_hole,
    output logic [6:0]       o_small_holes,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);

    localparam int unsigned N  = MAX_SEGMENTS;
    localparam int unsigned IW = $clog2(N);
    localparam int unsigned CW = $clog2(N + 1);
    localparam int unsigned SW = fsa_pkg::SIZE_BITS;
    localparam int unsigned AW = fsa_pkg::ADDR_BITS;
    localparam logic [IW-1:0] LAST = IW'(N - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(N);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_DEC   = 8'b0000_0100,
        ST_APPLY = 8'b0000_1000,
        ST_LO    = 8'b0001_0000,
        ST_HI    = 8'b0010_0000,
        ST_STAT  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;

    fsa_pkg::t_seg    w_seg [N];
    fsa_pkg::t_cell_op w_op;
    logic [IW-1:0]    w_idx;

    logic [1:0]       r_strategy;
    logic [SW-1:0]    r_pool;
    logic [SW-1:0]    r_small;
    logic [CW-1:0]    r_count;
    logic [IW-1:0]    r_cursor;

    logic [1:0]       r_action;
    logic [SW-1:0]    r_req;
    logic [AW-1:0]    r_off;
    logic [IW-1:0]    r_idx;

    logic             r_fnd, r_fnd2, r_chk, r_prev_used, r_lowm, r_highm, r_pres;
    logic [IW-1:0]    r_pick, r_pick2;
    logic [SW-1:0]    r_psz, r_psz2;
    logic [AW-1:0]    r_pst, r_pst2;

    logic [1:0]       r_sts;
    logic             r_split;
    logic [IW-1:0]    r_sel;
    logic [IW-1:0]    r_hidx;
    logic [AW-1:0]    r_where;

    logic [CW-1:0]    r_holes, r_smalls;
    logic [SW-1:0]    r_freeb, r_usedb, r_largest;

    logic             r_ovalid;
    logic [1:0]       r_o_status;
    logic [AW-1:0]    r_o_offset;
    logic             r_o_alloc;
    logic [CW-1:0]    r_o_holes, r_o_smalls;
    logic [SW-1:0]    r_o_free, r_o_used, r_o_largest;

    fsa_pkg::t_seg    w_head;
    logic             w_v, w_cand, w_upd, w_upd2;
    logic [IW-1:0]    w_c;
    logic             w_accept, w_cfg_wr, w_ok;

    logic             d_fsel;
    logic [IW-1:0]    d_psel;
    logic [SW-1:0]    d_szsel;
    logic [AW-1:0]    d_stsel;
    logic [1:0]       d_sts;
    logic             d_split;
    logic [IW-1:0]    d_cursor;
    logic [CW-1:0]    d_cnt1;
    logic [IW-1:0]    d_fc, d_ftt;
    logic [CW-1:0]    d_fcnt;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            localparam int unsigned LI = (k == 0) ? N - 1 : k - 1;
            localparam int unsigned RI = (k + 1) % N;
            fsa_cell #(
                .NUM (N),
                .IDX (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_idx   (w_idx),
                .i_left  (w_seg[LI]),
                .i_right (w_seg[RI]),
                .o_seg   (w_seg[k])
            );
        end
    endgenerate

    assign w_accept = i_valid && !o_stall;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;
    assign w_ok     = (r_sts == fsa_pkg::STS_OK);

    assign w_head = w_seg[0];
    assign w_v    = CW'(r_idx) < r_count;
    assign w_c    = (CW'(r_cursor) < r_count) ? r_cursor : '0;
    assign w_cand = w_v && !w_head.used && (w_head.size >= r_req);
    assign w_upd2 = w_cand && !r_fnd2 && (r_idx >= w_c);

    always_comb begin
        case (r_action)
            fsa_pkg::ACT_ALLOC: begin
                w_upd = w_cand && (!r_fnd
                    || (r_strategy == fsa_pkg::STRAT_BEST  && w_head.size < r_psz)
                    || (r_strategy == fsa_pkg::STRAT_WORST && w_head.size > r_psz));
            end
            fsa_pkg::ACT_FREE: begin
                w_upd = w_v && !r_fnd && (w_head.start == r_off);
            end
            fsa_pkg::ACT_PROBE: begin
                w_upd = w_v && !r_fnd && (r_off >= w_head.start)
                    && ({1'b0, r_off} < ({1'b0, w_head.start} + w_head.size));
            end
            default: begin
                w_upd = 1'b0;
            end
        endcase
    end

    always_comb begin
        d_fsel  = r_fnd;
        d_psel  = r_pick;
        d_szsel = r_psz;
        d_stsel = r_pst;
        if (r_strategy == fsa_pkg::STRAT_NEXT && r_fnd2) begin
            d_fsel  = 1'b1;
            d_psel  = r_pick2;
            d_szsel = r_psz2;
            d_stsel = r_pst2;
        end
        d_split = d_szsel > r_req;
        case (r_action)
            fsa_pkg::ACT_ALLOC: begin
                if (r_req == '0 || !d_fsel) d_sts = fsa_pkg::STS_NOFIT;
                else if (d_split && r_count >= FULL_CNT) d_sts = fsa_pkg::STS_FULL;
                else d_sts = fsa_pkg::STS_OK;
            end
            fsa_pkg::ACT_FREE: begin
                d_sts = r_fnd ? fsa_pkg::STS_OK : fsa_pkg::STS_BADOFF;
            end
            default: begin
                d_sts = fsa_pkg::STS_OK;
            end
        endcase

        d_cnt1   = r_count + CW'(d_split);
        d_cursor = r_cursor;
        if (r_action == fsa_pkg::ACT_ALLOC && d_sts == fsa_pkg::STS_OK) begin
            if (d_split && r_cursor > d_psel) d_cursor = r_cursor + IW'(1);
            if (r_strategy == fsa_pkg::STRAT_NEXT) begin
                d_cursor = (CW'(d_psel) + CW'(1) < d_cnt1) ? d_psel + IW'(1) : '0;
            end
        end

        d_fc   = r_cursor;
        d_ftt  = r_pick;
        d_fcnt = r_count;
        if (r_lowm) begin
            if (d_fc == d_ftt) d_fc = (CW'(d_ftt) + CW'(1) < d_fcnt) ? d_ftt : '0;
            else if (d_fc > d_ftt) d_fc = d_fc - IW'(1);
            d_fcnt = d_fcnt - CW'(1);
            d_ftt  = d_ftt - IW'(1);
        end
        if (r_highm) begin
            if ({1'b0, d_fc} == {1'b0, d_ftt} + (IW+1)'(1)) d_fc = d_ftt;
            else if ({1'b0, d_fc} > {1'b0, d_ftt} + (IW+1)'(1)) d_fc = d_fc - IW'(1);
        end
        if (r_action == fsa_pkg::ACT_FREE && r_fnd) d_cursor = d_fc;
    end

    always_comb begin
        w_op.code      = fsa_pkg::OP_HOLD;
        w_op.req       = r_req;
        w_op.init_size = fsa_pkg::clamp_pool(r_pool);
        w_idx          = r_sel;
        if (!i_rst_n) begin
            w_op.code      = fsa_pkg::OP_INIT;
            w_op.init_size = fsa_pkg::POOL_CAP;
        end else if (w_cfg_wr && (i_cfg_index == fsa_pkg::CFG_STRATEGY
                                  || i_cfg_index == fsa_pkg::CFG_POOL)) begin
            w_op.code = fsa_pkg::OP_INIT;
            if (i_cfg_index == fsa_pkg::CFG_POOL) begin
                w_op.init_size = fsa_pkg::clamp_pool(i_cfg_data);
            end
        end else begin
            case (r_state)
                ST_SCAN, ST_STAT: begin
                    w_op.code = fsa_pkg::OP_ROTATE;
                end
                ST_APPLY: begin
                    if (w_ok && r_action == fsa_pkg::ACT_ALLOC) begin
                        w_op.code = r_split ? fsa_pkg::OP_SPLIT : fsa_pkg::OP_MARK_USED;
                    end else if (w_ok && r_action == fsa_pkg::ACT_FREE) begin
                        w_op.code = fsa_pkg::OP_MARK_FREE;
                    end
                end
                ST_LO: begin
                    w_idx = r_sel - IW'(1);
                    if (r_action == fsa_pkg::ACT_FREE && r_lowm) w_op.code = fsa_pkg::OP_MERGE;
                end
                ST_HI: begin
                    w_idx = r_hidx;
                    if (r_action == fsa_pkg::ACT_FREE && r_highm) w_op.code = fsa_pkg::OP_MERGE;
                end
                default: begin
                    w_op.code = fsa_pkg::OP_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_strategy <= fsa_pkg::STRAT_FIRST;
            r_pool     <= fsa_pkg::POOL_CAP;
            r_small    <= '0;
            r_count    <= CW'(1);
            r_cursor   <= '0;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (r_ovalid && !i_stall && r_state != ST_DONE) r_ovalid <= 1'b0;

            if (w_cfg_wr) begin
                case (i_cfg_index)
                    fsa_pkg::CFG_STRATEGY: begin
                        r_strategy <= i_cfg_data[1:0];
                        r_count    <= CW'(1);
                        r_cursor   <= '0;
                    end
                    fsa_pkg::CFG_POOL: begin
                        r_pool   <= i_cfg_data;
                        r_count  <= CW'(1);
                        r_cursor <= '0;
                    end
                    fsa_pkg::CFG_SMALL: begin
                        r_small <= i_cfg_data;
                    end
                    default: begin
                        r_small <= r_small;
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_action    <= i_action;
                        r_req       <= i_request_size;
                        r_off       <= i_offset;
                        r_idx       <= '0;
                        r_fnd       <= 1'b0;
                        r_fnd2      <= 1'b0;
                        r_chk       <= 1'b0;
                        r_lowm      <= 1'b0;
                        r_highm     <= 1'b0;
                        r_pres      <= 1'b0;
                        r_prev_used <= 1'b0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_upd) begin
                        r_fnd  <= 1'b1;
                        r_pick <= r_idx;
                        r_psz  <= w_head.size;
                        r_pst  <= w_head.start;
                        r_pres <= w_head.used;
                        r_lowm <= (r_idx != '0) && !r_prev_used;
                    end
                    if (w_upd2) begin
                        r_fnd2  <= 1'b1;
                        r_pick2 <= r_idx;
                        r_psz2  <= w_head.size;
                        r_pst2  <= w_head.start;
                    end
                    r_chk       <= w_upd && (r_action == fsa_pkg::ACT_FREE);
                    if (r_chk) r_highm <= w_v && !w_head.used;
                    r_prev_used <= w_head.used;
                    r_idx       <= r_idx + IW'(1);
                    if (r_idx == LAST) r_state <= ST_DEC;
                end
                ST_DEC: begin
                    r_sts    <= d_sts;
                    r_split  <= d_split;
                    r_sel    <= (r_action == fsa_pkg::ACT_ALLOC) ? d_psel : r_pick;
                    r_hidx   <= r_lowm ? r_pick - IW'(1) : r_pick;
                    r_where  <= d_stsel;
                    r_cursor <= d_cursor;
                    r_state  <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (w_ok && r_action == fsa_pkg::ACT_ALLOC && r_split) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= ST_LO;
                end
                ST_LO: begin
                    if (r_action == fsa_pkg::ACT_FREE && r_lowm) r_count <= r_count - CW'(1);
                    r_state <= ST_HI;
                end
                ST_HI: begin
                    if (r_action == fsa_pkg::ACT_FREE && r_highm) r_count <= r_count - CW'(1);
                    r_idx     <= '0;
                    r_holes   <= '0;
                    r_smalls  <= '0;
                    r_freeb   <= '0;
                    r_usedb   <= '0;
                    r_largest <= '0;
                    r_state   <= ST_STAT;
                end
                ST_STAT: begin
                    if (w_v) begin
                        if (w_head.used) begin
                            r_usedb <= r_usedb + w_head.size;
                        end else begin
                            r_holes <= r_holes + CW'(1);
                            r_freeb <= r_freeb + w_head.size;
                            if (w_head.size > r_largest) r_largest <= w_head.size;
                            if (w_head.size <= r_small) r_smalls <= r_smalls + CW'(1);
                        end
                    end
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == LAST) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid    <= 1'b1;
                        r_o_status  <= r_sts;
                        r_o_offset  <= (r_action == fsa_pkg::ACT_ALLOC && w_ok) ? r_where : '0;
                        r_o_alloc   <= (r_action == fsa_pkg::ACT_PROBE) && r_fnd && r_pres;
                        r_o_holes   <= r_holes;
                        r_o_smalls  <= r_smalls;
                        r_o_free    <= r_freeb;
                        r_o_used    <= r_usedb;
                        r_o_largest <= r_largest;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_result_offset = r_o_offset;
    assign o_is_allocated  = r_o_alloc;
    assign o_free_segs     = 7'(r_o_holes);
    assign o_small_holes   = 7'(r_o_smalls);
    assign o_free_total    = r_o_free;
    assign o_used_total    = r_o_used;
    assign o_largest_hole  = r_o_largest;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= FULL_CNT))
        else $error("segment count out of range");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN))
        else $error("accepted item did not start a scan");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside completion");

    a_cursor_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (CW'(r_cursor) < r_count))
        else $error("cursor beyond table");

endmodule

`default_nettype wire
